FILE: rtl/vtpd_pkg.sv
// ============================================================================
// vtpd_pkg: shared types and constants of the vertex transform block
// Holds the matrix size, the fixed-point widths and the queue status type.
// ============================================================================
package vtpd_pkg;

    // Matrix size in use and the fixed storage side
    localparam int DIMENSION = 4;
    localparam int SIDE      = 4;

    // Field and datapath widths
    localparam int DW    = 32;           // Q16.16 word
    localparam int IDXW  = 2;            // row or column index
    localparam int PW    = 2 * DW;       // Q32.32 product
    localparam int SUMW  = PW + 2;       // exact sum of four products
    localparam int DOTW  = SUMW - 16;    // floored dot product
    localparam int QBITS = 33;           // quotient bits kept before clamping
    localparam int REMW  = DOTW + 16;    // scaled dividend
    localparam int CMPW  = DOTW + QBITS; // widest shifted divisor plus borrow
    localparam int NLANE = SIDE - 1;     // divided components

    // Stream widths
    localparam int IN_DW  = 168;
    localparam int OUT_DW = 128;

    // Queue between the front and the back
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Fixed-point constants
    localparam logic [DW-1:0]   ONE_Q16 = 32'h0001_0000;
    localparam logic [DW-1:0]   SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0]   SAT_MIN = 32'h8000_0000;
    localparam logic [DOTW-1:0] DOT_MAX = {{(DOTW - DW){1'b0}}, SAT_MAX};
    localparam logic [DOTW-1:0] DOT_MIN = {{(DOTW - DW){1'b1}}, SAT_MIN};
    localparam logic [QBITS-1:0] Q_POS_LIM = {1'b0, SAT_MAX};
    localparam logic [QBITS-1:0] Q_NEG_LIM = {1'b0, SAT_MIN};

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_opcode;

    typedef logic signed [DW-1:0] t_word;
    typedef t_word t_vec [SIDE];
    typedef t_word t_mat [SIDE][SIDE];

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

FILE: rtl/vtpd_front.sv
// ============================================================================
// vtpd_front: input decode and matrix store
// Takes input beats, writes matrix entries and hands vertices to the queue.
// ============================================================================
module vtpd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [vtpd_pkg::IN_DW-1:0]  i_data,
    input  logic [0:0]                  i_user,
    input  vtpd_pkg::t_q_status         i_q_status,
    output logic                        o_push,
    output vtpd_pkg::t_vec              o_vertex,
    output vtpd_pkg::t_mat              o_matrix
);

    vtpd_pkg::t_opcode               op;
    logic [vtpd_pkg::IDXW-1:0]       row;
    logic [vtpd_pkg::IDXW-1:0]       col;
    logic                            accept;
    logic                            wr_en;
    vtpd_pkg::t_mat                  r_matrix;

    // Field decode.
    assign op  = vtpd_pkg::t_opcode'(i_user[0]);
    assign row = i_data[1:0];
    assign col = i_data[3:2];

    always_comb begin
        for (int k = 0; k < vtpd_pkg::SIDE; k++) begin
            o_vertex[k] = i_data[36 + 32 * k +: 32];
        end
    end

    // A load waits until every queued vertex has read the matrix.
    assign o_ready = (op == vtpd_pkg::OP_XFORM) ? !i_q_status.full : i_q_status.empty;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (op == vtpd_pkg::OP_XFORM);
    assign wr_en   = accept && (op == vtpd_pkg::OP_LOAD) &&
                     (int'(row) < vtpd_pkg::DIMENSION) && (int'(col) < vtpd_pkg::DIMENSION);

    // Matrix coefficients, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < vtpd_pkg::SIDE; r++) begin
                for (int c = 0; c < vtpd_pkg::SIDE; c++) begin
                    r_matrix[r][c] <= '0;
                end
            end
        end else if (wr_en) begin
            r_matrix[row][col] <= i_data[35:4];
        end
    end

    assign o_matrix = r_matrix;

endmodule

FILE: rtl/vtpd_queue.sv
// ============================================================================
// vtpd_queue: vertex queue
// A short FIFO that decouples the decode front from the arithmetic back.
// ============================================================================
module vtpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vtpd_pkg::t_vec       i_vertex,
    input  logic                 i_pop,
    output logic                 o_valid,
    output vtpd_pkg::t_vec       o_vertex,
    output vtpd_pkg::t_q_status  o_status
);

    vtpd_pkg::t_vec                r_mem [vtpd_pkg::QDEPTH];
    logic [vtpd_pkg::QPW-1:0]      r_wr_ptr;
    logic [vtpd_pkg::QPW-1:0]      r_rd_ptr;
    logic [vtpd_pkg::QCW-1:0]      r_count;
    logic                          do_pop;

    assign do_pop          = i_pop && (r_count != '0);
    assign o_valid         = (r_count != '0);
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == vtpd_pkg::QCW'(vtpd_pkg::QDEPTH));
    assign o_vertex        = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_vertex;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == vtpd_pkg::QPW'(vtpd_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == vtpd_pkg::QPW'(vtpd_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/vtpd_back.sv
// ============================================================================
// vtpd_back: transform and divide pipeline
// Products, row sums, then a restoring divider with one quotient bit a stage.
// ============================================================================
module vtpd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  vtpd_pkg::t_vec               i_vertex,
    input  vtpd_pkg::t_mat               i_matrix,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [vtpd_pkg::OUT_DW-1:0]  o_data,
    output logic [1:0]                   o_user
);

    localparam int NST = vtpd_pkg::QBITS + 1;

    typedef struct packed {
        logic [vtpd_pkg::REMW-1:0]  rem;
        logic [vtpd_pkg::DOTW-1:0]  den;
        logic [vtpd_pkg::QBITS-1:0] quo;
        logic                       neg;
        logic                       ovf;
    } t_lane;

    typedef struct packed {
        t_lane [vtpd_pkg::NLANE-1:0]              lanes;
        logic  [vtpd_pkg::SIDE-1:0][vtpd_pkg::DW-1:0] raw;
        logic                                     raw_sat;
        logic                                     divided;
    } t_stage;

    logic                                en;
    logic signed [vtpd_pkg::PW-1:0]      r_prod [vtpd_pkg::SIDE][vtpd_pkg::SIDE];
    logic                                r_p0_valid;
    logic signed [vtpd_pkg::DOTW-1:0]    r_dot [vtpd_pkg::SIDE];
    logic signed [vtpd_pkg::DOTW-1:0]    n_dot [vtpd_pkg::SIDE];
    logic                                r_p1_valid;
    t_stage                              n_setup;
    t_stage                              r_stage [NST];
    t_stage                              n_stage [NST];
    logic [NST-1:0]                      r_st_valid;
    logic                                r_out_valid;
    logic [vtpd_pkg::OUT_DW-1:0]         r_out_data;
    logic [1:0]                          r_out_user;
    logic [vtpd_pkg::OUT_DW-1:0]         n_out_data;
    logic [1:0]                          n_out_user;

    // The whole pipeline advances unless a result waits at the output.
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_valid;

    // Stage 0: one product per matrix entry.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < vtpd_pkg::SIDE; r++) begin
                for (int c = 0; c < vtpd_pkg::SIDE; c++) begin
                    r_prod[r][c] <= vtpd_pkg::PW'(i_matrix[r][c]) *
                                    vtpd_pkg::PW'(i_vertex[c]);
                end
            end
        end
    end

    // Stage 1: exact row sums, floored once to Q16.16.
    always_comb begin
        logic signed [vtpd_pkg::SUMW-1:0] acc;
        for (int r = 0; r < vtpd_pkg::SIDE; r++) begin
            acc = '0;
            for (int c = 0; c < vtpd_pkg::SIDE; c++) begin
                acc = acc + vtpd_pkg::SUMW'(r_prod[r][c]);
            end
            n_dot[r] = acc[vtpd_pkg::SUMW-1:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dot <= n_dot;
        end
    end

    // Stage 2: weight test, clamped raw words, divider setup.
    always_comb begin
        logic [vtpd_pkg::DOTW-1:0] un;
        logic [vtpd_pkg::DOTW-1:0] ud;
        logic signed [vtpd_pkg::DOTW-1:0] wgt;
        wgt = r_dot[vtpd_pkg::DIMENSION-1];
        ud  = wgt[vtpd_pkg::DOTW-1] ? (~wgt + 1'b1) : wgt;
        n_setup.divided = (wgt != '0);
        n_setup.raw_sat = 1'b0;
        for (int i = 0; i < vtpd_pkg::SIDE; i++) begin
            if (r_dot[i] > $signed(vtpd_pkg::DOT_MAX)) begin
                n_setup.raw[i]  = vtpd_pkg::SAT_MAX;
                n_setup.raw_sat = 1'b1;
            end else if (r_dot[i] < $signed(vtpd_pkg::DOT_MIN)) begin
                n_setup.raw[i]  = vtpd_pkg::SAT_MIN;
                n_setup.raw_sat = 1'b1;
            end else begin
                n_setup.raw[i]  = r_dot[i][vtpd_pkg::DW-1:0];
            end
        end
        for (int l = 0; l < vtpd_pkg::NLANE; l++) begin
            un = r_dot[l][vtpd_pkg::DOTW-1] ? (~r_dot[l] + 1'b1) : r_dot[l];
            n_setup.lanes[l].rem = {un, 16'h0000};
            n_setup.lanes[l].den = ud;
            n_setup.lanes[l].quo = '0;
            n_setup.lanes[l].neg = r_dot[l][vtpd_pkg::DOTW-1] ^ wgt[vtpd_pkg::DOTW-1];
            // The quotient reaches 2**33 when the unscaled dividend is 2**17 times the divisor.
            n_setup.lanes[l].ovf = ({17'h0_0000, un} >= {ud, 17'h0_0000});
        end
    end

    // Divider stages: each one decides a single quotient bit, top bit first.
    always_comb begin
        logic [vtpd_pkg::CMPW-1:0] diff;
        n_stage[0] = n_setup;
        for (int s = 0; s < vtpd_pkg::QBITS; s++) begin
            n_stage[s + 1] = r_stage[s];
            for (int l = 0; l < vtpd_pkg::NLANE; l++) begin
                diff = {{(vtpd_pkg::CMPW - vtpd_pkg::REMW){1'b0}}, r_stage[s].lanes[l].rem} -
                       ({{(vtpd_pkg::CMPW - vtpd_pkg::DOTW){1'b0}}, r_stage[s].lanes[l].den}
                        << (vtpd_pkg::QBITS - 1 - s));
                if (!diff[vtpd_pkg::CMPW-1]) begin
                    n_stage[s + 1].lanes[l].rem = diff[vtpd_pkg::REMW-1:0];
                    n_stage[s + 1].lanes[l].quo[vtpd_pkg::QBITS-1-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NST; s++) begin
                r_stage[s] <= n_stage[s];
            end
        end
    end

    // Final selection: signed, clamped quotients with w set to one, or the raw words.
    always_comb begin
        logic [vtpd_pkg::QBITS-1:0] q;
        logic [vtpd_pkg::QBITS-1:0] nq;
        logic [vtpd_pkg::DW-1:0]    res;
        logic                       div_sat;
        t_stage                     st;
        st      = r_stage[NST-1];
        div_sat = 1'b0;
        q       = '0;
        nq      = '0;
        for (int i = 0; i < vtpd_pkg::SIDE; i++) begin
            res = '0;
            if (i < vtpd_pkg::NLANE) begin
                q  = st.lanes[i].quo;
                nq = ~q + 1'b1;
                if (st.lanes[i].ovf || (!st.lanes[i].neg && q > vtpd_pkg::Q_POS_LIM) ||
                    (st.lanes[i].neg && q > vtpd_pkg::Q_NEG_LIM)) begin
                    res = st.lanes[i].neg ? vtpd_pkg::SAT_MIN : vtpd_pkg::SAT_MAX;
                    if (i < vtpd_pkg::DIMENSION - 1) begin
                        div_sat = 1'b1;
                    end
                end else begin
                    res = st.lanes[i].neg ? nq[vtpd_pkg::DW-1:0] : q[vtpd_pkg::DW-1:0];
                end
            end
            if (i == vtpd_pkg::DIMENSION - 1) begin
                res = vtpd_pkg::ONE_Q16;
            end else if (i > vtpd_pkg::DIMENSION - 1) begin
                res = '0;
            end
            n_out_data[32 * i +: 32] = st.divided ? res : st.raw[i];
        end
        n_out_user[0] = st.divided;
        n_out_user[1] = st.divided ? div_sat : st.raw_sat;
    end

    // Valid chain and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_st_valid  <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p0_valid  <= i_valid;
            r_p1_valid  <= r_p0_valid;
            r_st_valid  <= {r_st_valid[NST-2:0], r_p1_valid};
            r_out_valid <= r_st_valid[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;

endmodule

FILE: rtl/vertex_transform_perspective_divide.sv
// ============================================================================
// vertex_transform_perspective_divide: 4x4 transform with perspective divide
// Signed Q16.16 matrix-vector product, divide by weight, saturating results.
// ============================================================================
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: opcode (0 load, 1 transform); tdata: row, col,
//                       value, x, y, z, w
//  m_axis    out        tdata: x, y, z, w; tuser: was_divided, saturated
//
//  One transform beat is taken every cycle while the queue has room; each goes
//  via products, row sums, divider setup, 33 divider stages, output register.
//  A load beat is taken only once the vertex queue is empty and gives no result.
//  Reset clears the matrix to zero and drops all beats in flight.
//  A stall on m_axis holds the whole back pipeline; the two-entry queue
//  keeps s_axis moving until it fills, one or two more beats.
// ============================================================================
module vertex_transform_perspective_divide (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] entry_row, [3:2] entry_col, [35:4] entry_value, [67:36] in_x,
    // [99:68] in_y, [131:100] in_z, [163:132] in_w, [167:164] zero
    input  logic [167:0] s_axis_tdata,
    // [0] opcode
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
    output logic [127:0] m_axis_tdata,
    // [0] was_divided, [1] saturated
    output logic [1:0]   m_axis_tuser
);

    vtpd_pkg::t_q_status q_status;
    vtpd_pkg::t_vec      push_vertex;
    vtpd_pkg::t_vec      head_vertex;
    vtpd_pkg::t_mat      matrix;
    logic                push;
    logic                pop;
    logic                head_valid;

    vtpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_user     (s_axis_tuser),
        .i_q_status (q_status),
        .o_push     (push),
        .o_vertex   (push_vertex),
        .o_matrix   (matrix)
    );

    vtpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_vertex (push_vertex),
        .i_pop    (pop),
        .o_valid  (head_valid),
        .o_vertex (head_vertex),
        .o_status (q_status)
    );

    vtpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_vertex (head_vertex),
        .i_matrix (matrix),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser)
    );

endmodule
